// ----- src/adcos_pkg.sv -----
// shared widths and codes for the adc oversampling channel scan block
`default_nettype none

package adcos_pkg;

    // datapath widths
    localparam int ACC_W      = 28;
    localparam int CNT_W      = 17;
    localparam int SLOT_W     = 4;
    localparam int CHAN_W     = 5;
    localparam int OUT_W      = 16;
    localparam int DEPTH_W    = 5;
    localparam int DEC_W      = 4;
    localparam int NSLOT_W    = 5;
    localparam int LIST_W     = 40;
    localparam int LIST_SLOTS = 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    // depth limits and output saturation
    localparam logic [DEPTH_W-1:0] DEPTH_MIN = 5'd1;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 5'd16;
    localparam logic [CNT_W-1:0]   CNT_MAX   = 17'h10000;
    localparam logic [OUT_W-1:0]   OUT_LIMIT = 16'hFFFF;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_CHANNELS    = 3'd0,
        REG_FILTER_DEPTH    = 3'd1,
        REG_DECIMATION_BITS = 3'd2,
        REG_CHAN_LIST_LOW   = 3'd3,
        REG_CHAN_LIST_HIGH  = 3'd4
    } cfg_reg_t;

endpackage

`default_nettype wire

// ----- src/adc_oversample_channel_scan_core.sv -----
// top level of the adc oversampling accumulator with round-robin channel scan
`default_nettype none

// One converter sample is taken per clock while in_stall is low. A sample is
// first captured in an input register; then one add into the 28-bit
// accumulator, one count compare, one barrel shift and a saturation compare
// update the slot state and, when 2^filter_depth samples have been summed,
// load the result register.
// A result is produced every 2^filter_depth samples; samples that complete no
// slot keep flowing even while a finished result waits on out_stall. The input
// only stalls when a slot completes while the result register is still held.
// Configuration writes are always taken (cfg_ready is high) and must only be
// issued while no sample is in flight.
module adc_oversample_channel_scan_core #(
    parameter int MAX_SLOTS   = 16,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // sample channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [SAMPLE_BITS-1:0]            sample,
    // result channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [adcos_pkg::SLOT_W-1:0]           slot_index,
    output logic [adcos_pkg::OUT_W-1:0]            average_value,
    output logic                                   clipped,
    output logic [adcos_pkg::CHAN_W-1:0]           next_channel,
    output logic                                   scan_done,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [adcos_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [adcos_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import adcos_pkg::*;

    localparam logic [NSLOT_W-1:0] SLOTS_MAX = NSLOT_W'(MAX_SLOTS);

    // configuration registers
    logic [NSLOT_W-1:0] num_channels_reg;
    logic [DEPTH_W-1:0] filter_depth_reg;
    logic [DEC_W-1:0]   decimation_bits_reg;
    logic [LIST_W-1:0]  chan_list_low_reg;
    logic [LIST_W-1:0]  chan_list_high_reg;

    // input stage
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic                   s1_advance;

    // slot state
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;

    // result register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [SLOT_W-1:0] res_slot_reg;
    logic [OUT_W-1:0]  res_avg_reg;
    logic              res_clip_reg;
    logic [CHAN_W-1:0] res_chan_reg;
    logic              res_done_reg;

    // datapath signals
    logic [DEPTH_W-1:0] depth_eff;
    logic [NSLOT_W-1:0] slots_eff;
    logic [DEPTH_W-1:0] shift_amt;
    logic [ACC_W-1:0]   acc_sum;
    logic [CNT_W-1:0]   cnt_inc;
    logic [CNT_W-1:0]   cnt_limit;
    logic               slot_complete;
    logic [ACC_W-1:0]   sum_shifted;
    logic               sum_clip;
    logic [OUT_W-1:0]   sum_sat;
    logic [NSLOT_W-1:0] slot_inc;
    logic               slot_wrap;
    logic [SLOT_W-1:0]  slot_new;
    logic [CHAN_W-1:0]  chan_tab [2*LIST_SLOTS];
    logic               out_free;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_channels_reg    <= NSLOT_W'(1);
            filter_depth_reg    <= DEPTH_W'(4);
            decimation_bits_reg <= '0;
            chan_list_low_reg   <= '0;
            chan_list_high_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_NUM_CHANNELS:    num_channels_reg    <= cfg_data[NSLOT_W-1:0];
                REG_FILTER_DEPTH:    filter_depth_reg    <= cfg_data[DEPTH_W-1:0];
                REG_DECIMATION_BITS: decimation_bits_reg <= cfg_data[DEC_W-1:0];
                REG_CHAN_LIST_LOW:   chan_list_low_reg   <= cfg_data[LIST_W-1:0];
                REG_CHAN_LIST_HIGH:  chan_list_high_reg  <= cfg_data[LIST_W-1:0];
                default:             ;
            endcase
        end
    end

    // clamp depth and slot count into range
    always_comb
    begin
        if (filter_depth_reg < DEPTH_MIN)
            depth_eff = DEPTH_MIN;
        else if (filter_depth_reg > DEPTH_MAX)
            depth_eff = DEPTH_MAX;
        else
            depth_eff = filter_depth_reg;

        if (num_channels_reg == '0)
            slots_eff = NSLOT_W'(1);
        else if (num_channels_reg > SLOTS_MAX)
            slots_eff = SLOTS_MAX;
        else
            slots_eff = num_channels_reg;
    end

    // channel lookup table from the two list registers
    always_comb
    begin
        for (int i = 0; i < LIST_SLOTS; i++)
        begin
            chan_tab[i]              = chan_list_low_reg[i*CHAN_W +: CHAN_W];
            chan_tab[i + LIST_SLOTS] = chan_list_high_reg[i*CHAN_W +: CHAN_W];
        end
    end

    // accumulate, detect completion, shift and saturate
    always_comb
    begin
        acc_sum       = acc_reg + ACC_W'(s1_sample_reg);
        cnt_inc       = count_reg + CNT_W'(1);
        cnt_limit     = CNT_W'(1) << depth_eff;
        slot_complete = cnt_inc >= cnt_limit;

        if (depth_eff > DEPTH_W'(decimation_bits_reg))
            shift_amt = depth_eff - DEPTH_W'(decimation_bits_reg);
        else
            shift_amt = '0;

        sum_shifted = acc_sum >> shift_amt;
        sum_clip    = |sum_shifted[ACC_W-1:OUT_W];
        sum_sat     = sum_clip ? OUT_LIMIT : sum_shifted[OUT_W-1:0];

        slot_inc  = NSLOT_W'(slot_reg) + NSLOT_W'(1);
        slot_wrap = slot_inc >= slots_eff;
        slot_new  = slot_wrap ? '0 : slot_inc[SLOT_W-1:0];
    end

    // handshake: a completing sample needs room in the result register
    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = !slot_complete || out_free;
    assign in_stall   = s1_valid_reg && !s1_advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (!s1_valid_reg || s1_advance)
            s1_valid_next = in_valid;

        acc_next   = acc_reg;
        count_next = count_reg;
        slot_next  = slot_reg;
        if (s1_valid_reg && s1_advance)
        begin
            if (slot_complete)
            begin
                acc_next   = '0;
                count_next = '0;
                slot_next  = slot_new;
            end
            else
            begin
                acc_next   = acc_sum;
                count_next = cnt_inc;
            end
        end

        out_valid_next = out_valid_reg && out_stall;
        if (s1_valid_reg && s1_advance && slot_complete)
            out_valid_next = 1'b1;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            count_reg     <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!s1_valid_reg || s1_advance)
            s1_sample_reg <= sample;

        if (s1_valid_reg && s1_advance && slot_complete)
        begin
            res_slot_reg <= slot_reg;
            res_avg_reg  <= sum_sat;
            res_clip_reg <= sum_clip;
            res_chan_reg <= chan_tab[slot_new];
            res_done_reg <= slot_wrap;
        end
    end

    // result outputs
    assign out_valid     = out_valid_reg;
    assign slot_index    = res_slot_reg;
    assign average_value = res_avg_reg;
    assign clipped       = res_clip_reg;
    assign next_channel  = res_chan_reg;
    assign scan_done     = res_done_reg;

    // sample count is cleared before it can pass the largest block size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CNT_MAX)
        else $error("sample count passed largest block size");

    // slot position stays inside the slot table
    assert property (@(posedge clk) disable iff (!rst_n)
        NSLOT_W'(slot_reg) < SLOTS_MAX)
        else $error("slot position out of range");

    // a completed slot clears its accumulator and count
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_advance && slot_complete)
        |=> (acc_reg == '0 && count_reg == '0))
        else $error("slot state not cleared after completion");

    // the input only stalls behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled without a held result");

    // a clipped result carries the saturation value
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_clip_reg) |-> (res_avg_reg == OUT_LIMIT))
        else $error("clipped result not saturated");

endmodule

`default_nettype wire
